[hdl/ctst_pkg.sv]
// Package for the multitouch contact slot tracker.
// Holds the slot count, phase and event codes, slot entry and result types.
// Used by ctst_out_buf and the top level; depends on nothing.
`timescale 1ns / 1ps

package ctst_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int SLOT_AW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [1:0] {
    PH_NONE,
    PH_DOWN,
    PH_MOVE,
    PH_UP
  } phase_t;

  typedef enum logic [1:0] {
    EV_PRESSED,
    EV_MOVED,
    EV_RELEASED,
    EV_ERROR
  } event_t;

  typedef enum logic [1:0] {
    TK_DOWN,
    TK_MOVE,
    TK_UP,
    TK_UNKNOWN
  } touch_kind_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] contact;
    logic        in_use;
    logic        pending;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic [2:0]  slot;
    event_t      code;
    logic [15:0] x;
    logic [15:0] y;
  } result_t;

  typedef struct packed {
    logic load;
    logic flush;
    logic err;
  } obuf_ctl_t;

  typedef struct packed {
    logic out_free;
    logic held_valid;
  } obuf_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PROC,
    ST_WRITE,
    ST_ERROR,
    ST_FLUSH
  } seq_state_t;

endpackage

[hdl/ctst_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters; no other dependencies.
`timescale 1ns / 1ps

module ctst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/ctst_out_buf.sv]
// Result buffer: one holding stage plus the output register of the result stream.
// The holding stage delays each result until it is known whether it is the last one.
// Depends on ctst_pkg.
`timescale 1ns / 1ps

module ctst_out_buf (
  input  logic                                clk,
  input  logic                                rst,
  input  ctst_pkg::obuf_ctl_t                 ctl,
  input  ctst_pkg::result_t                   res,
  output ctst_pkg::obuf_stat_t                stat,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // Fields from bit 0: slot_index[2:0], out_x[18:3], out_y[34:19], zero fill.
  output logic [ctst_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // Fields from bit 0: event_code[1:0].
  output logic [ctst_pkg::OUT_TUSER_W-1:0]    m_tuser,
  output logic                                m_tlast
);

  import ctst_pkg::*;

  result_t held;
  logic    held_valid;
  result_t out_res;
  result_t err_res;

  assign err_res = '{slot: 3'd0, code: EV_ERROR, x: 16'd0, y: 16'd0};

  assign stat.out_free   = !m_tvalid || m_tready;
  assign stat.held_valid = held_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (ctl.load) begin
        held       <= res;
        held_valid <= 1'b1;
      end else if (ctl.flush) begin
        held_valid <= 1'b0;
      end

      if (ctl.load && held_valid) begin
        out_res  <= held;
        m_tlast  <= 1'b0;
        m_tvalid <= 1'b1;
      end else if (ctl.flush) begin
        out_res  <= held;
        m_tlast  <= 1'b1;
        m_tvalid <= 1'b1;
      end else if (ctl.err) begin
        out_res  <= err_res;
        m_tlast  <= 1'b1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {5'd0, out_res.y, out_res.x, out_res.slot};
  assign m_tuser = out_res.code;

endmodule

[hdl/multitouch_contact_slot_tracker.sv]
// Top level of the multitouch contact slot tracker: sequencer, slot memory, result buffer.
// Depends on ctst_pkg, ctst_ram and ctst_out_buf.
`timescale 1ns / 1ps

// Slot entries sit in one memory of NUM_SLOTS entries that is read one slot at a time,
// with a read step and a process step per slot. A touch report searches every slot for
// its contact or a free slot and then writes that slot; a report that finds no slot
// writes nothing and returns one error result, waiting while the result stream is held
// back. An unknown touch kind is dropped. A tick writes each slot back after reading it,
// waiting while the result stream is held back, and sends at most MAX_RESULTS results,
// the final one marked by tlast. Per-slot valid flags make every slot read as empty after
// reset, so no clearing pass is needed.
module multitouch_contact_slot_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // Fields from bit 0: pos_x[15:0], pos_y[31:16], contact_id[47:32].
  input  logic [ctst_pkg::IN_TDATA_W-1:0]     s_tdata,
  // Fields from bit 0: command[0], touch_kind[2:1].
  input  logic [ctst_pkg::IN_TUSER_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // Fields from bit 0: slot_index[2:0], out_x[18:3], out_y[34:19], zero fill.
  output logic [ctst_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // Fields from bit 0: event_code[1:0].
  output logic [ctst_pkg::OUT_TUSER_W-1:0]    m_tuser,
  output logic                                m_tlast
);

  import ctst_pkg::*;

  seq_state_t state, state_next;

  logic                 cmd;
  touch_kind_t          kind;
  logic [15:0]          pos_x, pos_y, contact_id;
  logic [SLOT_AW-1:0]   idx;
  logic [CNT_W-1:0]     res_cnt;
  logic [NUM_SLOTS-1:0] valid;

  logic               match_hit, free_hit;
  logic [SLOT_AW-1:0] match_idx, free_idx;
  phase_t             match_phase, free_phase;
  logic               match_pend, free_pend;

  logic               ram_we, ram_re;
  logic [SLOT_AW-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  slot_entry_t ent, tick_ent, rep_ent;
  logic        is_last;
  logic        emit, tick_take, tick_go;
  event_t      tick_code;
  result_t     res;

  logic               sel_hit, sel_pend;
  logic [SLOT_AW-1:0] sel_idx;
  phase_t             sel_phase, new_phase;

  obuf_ctl_t  ctl;
  obuf_stat_t stat;

  ctst_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  ctst_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .res      (res),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  assign ent     = valid[idx] ? slot_entry_t'(ram_rdata) : '0;
  assign is_last = (idx == SLOT_AW'(NUM_SLOTS - 1));

  always_comb begin
    tick_ent  = ent;
    emit      = 1'b1;
    tick_code = EV_PRESSED;
    unique case (ent.phase)
      PH_DOWN: begin
        tick_ent.phase   = PH_MOVE;
        tick_ent.pending = 1'b0;
      end
      PH_MOVE: begin
        tick_code        = ent.pending ? EV_PRESSED : EV_MOVED;
        tick_ent.pending = 1'b0;
      end
      PH_UP: begin
        tick_code        = EV_RELEASED;
        tick_ent         = '0;
        tick_ent.pending = ent.pending;
      end
      PH_NONE: begin
        emit = 1'b0;
      end
    endcase
  end

  assign tick_take = emit && (res_cnt < CNT_W'(MAX_RESULTS));
  assign tick_go   = !tick_take || !stat.held_valid || stat.out_free;
  assign res       = '{slot: 3'(idx), code: tick_code, x: ent.x, y: ent.y};

  always_comb begin
    sel_hit   = match_hit || free_hit;
    sel_idx   = match_hit ? match_idx : free_idx;
    sel_phase = match_hit ? match_phase : free_phase;
    sel_pend  = match_hit ? match_pend : free_pend;
    new_phase = phase_t'(kind + 2'd1);
    if (new_phase == PH_DOWN && (sel_phase == PH_DOWN || sel_phase == PH_MOVE)) begin
      new_phase = PH_MOVE;
    end
    rep_ent.phase   = new_phase;
    rep_ent.x       = pos_x;
    rep_ent.y       = pos_y;
    rep_ent.contact = contact_id;
    rep_ent.in_use  = 1'b1;
    rep_ent.pending = (new_phase == PH_DOWN) ? 1'b1 : sel_pend;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && (s_tuser[0] == CMD_TICK ||
                         touch_kind_t'(s_tuser[2:1]) != TK_UNKNOWN)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_PROC;
      ST_PROC: begin
        if (cmd == CMD_TICK) begin
          if (tick_go) begin
            state_next = is_last ? ST_FLUSH : ST_READ;
          end
        end else begin
          state_next = is_last ? ST_WRITE : ST_READ;
        end
      end
      ST_WRITE: state_next = sel_hit ? ST_IDLE : ST_ERROR;
      ST_ERROR: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!stat.held_valid || stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    ram_re    = (state == ST_READ);
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = tick_ent;
    ctl       = '0;
    unique case (state)
      ST_PROC: begin
        if (cmd == CMD_TICK && tick_go) begin
          ram_we   = 1'b1;
          ctl.load = tick_take;
        end
      end
      ST_WRITE: begin
        ram_we    = sel_hit;
        ram_waddr = sel_idx;
        ram_wdata = rep_ent;
      end
      ST_ERROR: ctl.err   = stat.out_free;
      ST_FLUSH: ctl.flush = stat.held_valid && stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      valid   <= '0;
      res_cnt <= '0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      if (state == ST_IDLE) begin
        res_cnt <= '0;
      end else if (ctl.load) begin
        res_cnt <= res_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      cmd        <= s_tuser[0];
      kind       <= touch_kind_t'(s_tuser[2:1]);
      pos_x      <= s_tdata[15:0];
      pos_y      <= s_tdata[31:16];
      contact_id <= s_tdata[47:32];
      idx        <= '0;
      match_hit  <= 1'b0;
      free_hit   <= 1'b0;
    end else if (state == ST_PROC) begin
      if (cmd == CMD_REPORT) begin
        if (ent.in_use && ent.contact == contact_id && !match_hit) begin
          match_hit   <= 1'b1;
          match_idx   <= idx;
          match_phase <= ent.phase;
          match_pend  <= ent.pending;
        end
        if (!ent.in_use && !free_hit) begin
          free_hit   <= 1'b1;
          free_idx   <= idx;
          free_phase <= ent.phase;
          free_pend  <= ent.pending;
        end
      end
      if ((cmd == CMD_REPORT || tick_go) && !is_last) begin
        idx <= idx + SLOT_AW'(1);
      end
    end
  end

  a_idle_no_held : assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !stat.held_valid)
    else $error("result held while sequencer idle");

  a_cnt_bound : assert property (@(posedge clk) disable iff (rst)
    res_cnt <= CNT_W'(MAX_RESULTS))
    else $error("result count beyond limit");

  a_err_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == EV_ERROR) |-> (m_tlast && m_tdata[2:0] == 3'd0))
    else $error("error result not final or not slot zero");

  a_we_state : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_PROC || state == ST_WRITE))
    else $error("slot memory written outside a scan or write step");

endmodule
